// ===== hw/rtl/ntpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types, constants, microcode program and helper functions of the
// NTP seconds to BCD calendar converter.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  localparam logic [31:0] EPOCH_DIFF = 32'd3155673600;

  // signed working count: 32-bit base plus offset needs 34 bits
  localparam int unsigned TW = 34;
  localparam int unsigned KW = 25;

  localparam logic [KW-1:0] SEC_YEAR = 25'd31536000;
  localparam logic [KW-1:0] SEC_LEAP = 25'd31622400;
  localparam logic [KW-1:0] SEC_DAY  = 25'd86400;
  localparam logic [KW-1:0] SEC_HOUR = 25'd3600;
  localparam logic [KW-1:0] SEC_MIN  = 25'd60;

  localparam int unsigned CFG_IW = 8;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_UTC_OFFSET = 8'd0;
  localparam logic [CFG_IW-1:0] REG_DST        = 8'd1;

  localparam logic [3:0] MONTH_DEC = 4'd11;
  localparam logic [7:0] YEAR_MAX  = 8'h99;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_OOR  = 4'd8;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_NEG,
    OP_YEAR,
    OP_MONTH,
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_EMIT,
    OP_OOR
  } op_e;

  typedef enum logic [1:0] {
    SQ_WAIT_IN,
    SQ_BRANCH,
    SQ_LOOP,
    SQ_EMIT
  } sq_e;

  typedef struct packed {
    op_e op;
    sq_e sq;
    pc_t target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic exec;
  } dp_ctrl_t;

  typedef struct packed {
    logic more;
    logic jump;
    logic out_free;
  } dp_stat_t;

  // control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_LOAD,  sq: SQ_WAIT_IN, target: PC_IDLE};
      4'd1:    w = '{op: OP_NEG,   sq: SQ_BRANCH,  target: PC_OOR};
      4'd2:    w = '{op: OP_YEAR,  sq: SQ_LOOP,    target: PC_OOR};
      4'd3:    w = '{op: OP_MONTH, sq: SQ_LOOP,    target: PC_OOR};
      4'd4:    w = '{op: OP_DAY,   sq: SQ_LOOP,    target: PC_OOR};
      4'd5:    w = '{op: OP_HOUR,  sq: SQ_LOOP,    target: PC_OOR};
      4'd6:    w = '{op: OP_MIN,   sq: SQ_LOOP,    target: PC_OOR};
      4'd7:    w = '{op: OP_EMIT,  sq: SQ_EMIT,    target: PC_IDLE};
      4'd8:    w = '{op: OP_OOR,   sq: SQ_EMIT,    target: PC_IDLE};
      default: w = '{op: OP_LOAD,  sq: SQ_WAIT_IN, target: PC_IDLE};
    endcase
    return w;
  endfunction

  // length of a month in seconds, month index from 0
  function automatic logic [KW-1:0] month_sec(logic [3:0] m, logic leap);
    logic [KW-1:0] s;
    unique case (m)
      4'd1:                      s = leap ? 25'd2505600 : 25'd2419200;
      4'd3, 4'd5, 4'd8, 4'd10:   s = 25'd2592000;
      default:                   s = 25'd2678400;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] bcd_inc(logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] == 4'd9) begin
      r = {v[7:4] + 4'd1, 4'd0};
    end else begin
      r = {v[7:4], v[3:0] + 4'd1};
    end
    return r;
  endfunction

  // 0..59 binary to two BCD digits
  function automatic logic [6:0] sec_to_bcd(logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    priority if (v >= 6'd50) begin
      tens = 3'd5; ones = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 3'd4; ones = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 3'd3; ones = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 3'd2; ones = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 3'd1; ones = v - 6'd10;
    end else begin
      tens = 3'd0; ones = v;
    end
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== hw/rtl/ntpc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_seq
// Microprogram sequencer: step counter, control store lookup, branching.
// ----------------------------------------------------------------------------
module ntpc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ntpc_pkg::dp_stat_t stat_i,
  output ntpc_pkg::dp_ctrl_t ctrl_o
);
  import ntpc_pkg::*;

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   exec;

  assign uw = ucode(pc_q);

  always_comb begin
    pc_d = pc_q;
    exec = 1'b0;
    unique case (uw.sq)
      SQ_WAIT_IN: begin
        exec = in_valid_i;
        if (in_valid_i) pc_d = pc_q + 4'd1;
      end
      SQ_BRANCH: begin
        pc_d = stat_i.jump ? uw.target : pc_q + 4'd1;
      end
      SQ_LOOP: begin
        priority if (stat_i.jump) begin
          pc_d = uw.target;
        end else if (stat_i.more) begin
          exec = 1'b1;
        end else begin
          pc_d = pc_q + 4'd1;
        end
      end
      SQ_EMIT: begin
        exec = stat_i.out_free;
        if (stat_i.out_free) pc_d = uw.target;
      end
      default: pc_d = PC_IDLE;
    endcase
  end

  assign in_ready_o  = (uw.sq == SQ_WAIT_IN);
  assign ctrl_o.op   = uw.op;
  assign ctrl_o.exec = exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hw/rtl/ntpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_dp
// Datapath: offset registers, working count with one subtractor, BCD field
// counters, a binary month counter and the result register.
// ----------------------------------------------------------------------------
module ntpc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ntpc_pkg::dp_ctrl_t           ctrl_i,
  output ntpc_pkg::dp_stat_t           stat_o,
  input  logic [31:0]                  ntp_seconds_i,
  input  logic                         cfg_we_i,
  input  logic [ntpc_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [ntpc_pkg::CFG_DW-1:0]  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [39:0]                  out_data_o,
  output logic                         out_oor_o
);
  import ntpc_pkg::*;

  logic [10:0] off_q;
  logic        dst_q;

  logic signed [TW-1:0] t_q, t_d;
  logic [7:0] year_q, year_d;
  logic [3:0] mon_q, mon_d;
  logic [5:0] day_q, day_d;
  logic [5:0] hour_q, hour_d;
  logic [6:0] min_q, min_d;

  logic        out_valid_q, out_valid_d;
  logic [39:0] out_data_q, out_data_d;
  logic        out_oor_q, out_oor_d;

  logic signed [11:0] off_min;
  logic signed [17:0] off_sec;
  logic [31:0]        base;
  logic signed [TW-1:0] t_load;
  logic        leap;
  logic [KW-1:0] k;
  logic signed [TW-1:0] diff;
  logic        ge;
  logic        out_free;
  logic [4:0]  month_out;

  // offset in minutes, plus an hour for daylight saving
  assign off_min = $signed({off_q[10], off_q}) + (dst_q ? 12'sd60 : 12'sd0);
  assign off_sec = 18'(off_min) * 18'sd60;
  assign base    = ntp_seconds_i - EPOCH_DIFF;
  assign t_load  = $signed({2'b00, base}) + TW'(off_sec);

  // year 2000 counts as leap; no other century year in range
  assign leap = ~year_q[0] & (year_q[1] == year_q[4]);

  always_comb begin
    unique case (ctrl_i.op)
      OP_YEAR:  k = leap ? SEC_LEAP : SEC_YEAR;
      OP_MONTH: k = month_sec(mon_q, leap);
      OP_DAY:   k = SEC_DAY;
      OP_HOUR:  k = SEC_HOUR;
      OP_MIN:   k = SEC_MIN;
      default:  k = SEC_MIN;
    endcase
  end

  assign diff     = t_q - $signed({{(TW-KW){1'b0}}, k});
  assign ge       = ~diff[TW-1];
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    stat_o.out_free = out_free;
    stat_o.more     = ge;
    stat_o.jump     = 1'b0;
    unique case (ctrl_i.op)
      OP_NEG:   stat_o.jump = t_q[TW-1];
      OP_YEAR:  stat_o.jump = ge & (year_q == YEAR_MAX);
      OP_MONTH: stat_o.more = ge & (mon_q != MONTH_DEC);
      default:  stat_o.jump = 1'b0;
    endcase
  end

  assign month_out = (mon_q >= 4'd9) ? {1'b1, mon_q - 4'd9} : {1'b0, mon_q + 4'd1};

  always_comb begin
    t_d         = t_q;
    year_d      = year_q;
    mon_d       = mon_q;
    day_d       = day_q;
    hour_d      = hour_q;
    min_d       = min_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    out_oor_d   = out_oor_q;
    if (ctrl_i.exec) begin
      unique case (ctrl_i.op)
        OP_LOAD: begin
          t_d    = t_load;
          year_d = 8'h00;
          mon_d  = 4'd0;
          day_d  = 6'h01;
          hour_d = 6'h00;
          min_d  = 7'h00;
        end
        OP_YEAR: begin
          t_d    = diff;
          year_d = bcd_inc(year_q);
        end
        OP_MONTH: begin
          t_d   = diff;
          mon_d = mon_q + 4'd1;
        end
        OP_DAY: begin
          t_d   = diff;
          day_d = 6'(bcd_inc({2'b00, day_q}));
        end
        OP_HOUR: begin
          t_d    = diff;
          hour_d = 6'(bcd_inc({2'b00, hour_q}));
        end
        OP_MIN: begin
          t_d   = diff;
          min_d = 7'(bcd_inc({1'b0, min_q}));
        end
        OP_EMIT: begin
          out_valid_d = 1'b1;
          out_oor_d   = 1'b0;
          out_data_d  = {1'b0, sec_to_bcd(t_q[5:0]), min_q, hour_q, day_q,
                         month_out, year_q};
        end
        OP_OOR: begin
          out_valid_d = 1'b1;
          out_oor_d   = 1'b1;
          out_data_d  = '0;
        end
        default: t_d = t_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      dst_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == REG_UTC_OFFSET) off_q <= cfg_data_i[10:0];
      if (cfg_we_i && cfg_index_i == REG_DST)        dst_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    year_q     <= year_d;
    mon_q      <= mon_d;
    day_q      <= day_d;
    hour_q     <= hour_d;
    min_q      <= min_d;
    out_data_q <= out_data_d;
    out_oor_q  <= out_oor_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_oor_o   = out_oor_q;

endmodule

// ===== hw/rtl/ntp_seconds_to_bcd_calendar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_seconds_to_bcd_calendar
// NTP era 0 seconds to local BCD calendar date and time of day.
// ----------------------------------------------------------------------------
// One item is converted at a time. The input is taken, then a
// microcoded sequencer drives a single 34-bit subtractor that strips whole
// years, months, days, hours and minutes one per cycle. The emit step waits
// until the previous result has been taken. The result sits in an output
// register, so the next item is taken while it waits. Times before 2000 or
// beyond 2099 give a transfer with out_of_range (tuser) set and all date
// fields zero. Config writes are always ready and should only be made while
// no conversion is in flight.
module ntp_seconds_to_bcd_calendar (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] ntp_seconds
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] year_bcd, [12:8] month_bcd, [18:13] day_bcd, [24:19] hour_bcd,
  // [31:25] minute_bcd, [38:32] second_bcd, [39] zero
  output logic [39:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,  // [0] out_of_range
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ntpc_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [ntpc_pkg::CFG_DW-1:0] cfg_data_i
);
  import ntpc_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ntpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ntpc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .ntp_seconds_i (s_axis_tdata),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_oor_o     (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/ntpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_checker
// Port-level checks of the calendar converter, bound to the top level.
// ----------------------------------------------------------------------------
module ntpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a result is held until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // one conversion at a time: no input right after a transfer in
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while converting");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
    else $error("out of range result carries date bits");

  // a real date never has month or day zero
  a_date_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[12:8] != 5'd0 && m_axis_tdata[18:13] != 6'd0)
    else $error("month or day zero in valid date");

endmodule

bind ntp_seconds_to_bcd_calendar ntpc_checker u_ntpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NTP seconds to BCD calendar converter.
// ----------------------------------------------------------------------------
// NTP second counts are streamed in and every calendar transfer that comes out
// is checked field by field against a local calculation of the date. The
// first block holds directed edge dates at the reset setting. Six phases then
// follow, each with its own UTC offset and DST setting and its own pattern of
// sender gaps and receiver stalls. Nearly half the random counts land on or
// near month, day and range boundaries in local time. One phase holds the output
// back for a long stretch so that the converter fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import ntpc_pkg::*;

  localparam longint EPOCH_NTP_S = 64'd3155673600;  // 1900 to 2000
  localparam longint SPAN_S      = 64'd3155760000;  // 2000-01-01 to 2100-01-01
  localparam longint DAY_S       = 64'd86400;
  localparam int     ITEMS_PER_PHASE = 265;
  localparam int     SETTLE_CYCLES   = 300;
  localparam int     HOLD_CYCLES     = 800;

  typedef struct packed {
    logic [31:0] ntp;
    logic        oor;
    logic [39:0] date;
  } calendar_t;

  typedef struct packed {
    logic [CFG_IW-1:0] idx;
    logic [CFG_DW-1:0] data;
  } reg_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  logic [10:0] cur_offset = '0;
  logic        cur_dst = 1'b0;

  logic [31:0] ntp_backlog[$];
  calendar_t   calendar_due[$];
  reg_write_t  reg_backlog[$];

  int idle_pct = 0;
  int stall_pct = 0;
  longint cycle_cnt = 0;
  longint hold_until = 0;
  int mismatch_count = 0;
  int items_taken = 0;
  int dates_seen = 0;
  int oor_seen = 0;

  ntp_seconds_to_bcd_calendar uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- calendar
  function automatic bit is_leap(int y);
    int full;
    full = y + 2000;
    return (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
  endfunction

  function automatic int month_days(int m, bit leap);
    int d;
    case (m)
      1:           d = leap ? 29 : 28;
      3, 5, 8, 10: d = 30;
      default:     d = 31;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] bcd8(int v);
    return 8'(((v / 10) % 10) * 16 + v % 10);
  endfunction

  function automatic longint offset_secs(logic [10:0] off, logic dst);
    return (longint'($signed(off)) + (dst ? 60 : 0)) * 60;
  endfunction

  function automatic calendar_t ntp_to_calendar(logic [31:0] ntp, logic [10:0] off,
                                                logic dst);
    calendar_t   c;
    logic [31:0] base;
    longint      t;
    int          yr, mo, dy, hr, mi, se;
    bit          leap;
    c = '0;
    c.ntp = ntp;
    base = ntp - 32'(EPOCH_NTP_S);
    t = longint'(base) + offset_secs(off, dst);
    yr = 0;
    mo = 0;
    if (t < 0) begin
      c.oor = 1'b1;
      return c;
    end
    while (t >= (is_leap(yr) ? 366 : 365) * DAY_S) begin
      t -= (is_leap(yr) ? 366 : 365) * DAY_S;
      yr++;
      if (yr > 99) begin
        c.oor = 1'b1;
        return c;
      end
    end
    leap = is_leap(yr);
    while (mo < 11 && t >= month_days(mo, leap) * DAY_S) begin
      t -= month_days(mo, leap) * DAY_S;
      mo++;
    end
    dy = int'(t / DAY_S) + 1;
    t = t % DAY_S;
    hr = int'(t / 3600);
    mi = int'((t % 3600) / 60);
    se = int'(t % 60);
    c.date = {1'b0, 7'(bcd8(se)), 7'(bcd8(mi)), 6'(bcd8(hr)), 6'(bcd8(dy)),
              5'(bcd8(mo + 1)), bcd8(yr)};
    return c;
  endfunction

  // seconds since 2000 at the start of month m of year y
  function automatic longint month_start(int y, int m);
    longint days;
    days = 0;
    for (int i = 0; i < y; i++) days += is_leap(i) ? 366 : 365;
    for (int i = 0; i < m; i++) days += month_days(i, is_leap(y));
    return days * DAY_S;
  endfunction

  function automatic logic [31:0] ntp_of(longint base);
    return 32'(base + EPOCH_NTP_S);
  endfunction

  // local-time boundaries, uniform dates and some raw noise
  function automatic logic [31:0] random_ntp();
    int     r;
    longint b;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      b = longint'($urandom_range(0, 32'(SPAN_S - 1)));
    end else if (r < 75) begin
      b = month_start($urandom_range(0, 100), $urandom_range(0, 11))
          - offset_secs(cur_offset, cur_dst);
      if ($urandom_range(0, 3) == 0) b += longint'($urandom_range(0, 86399));
      else b += longint'($urandom_range(0, 6)) - 3;
    end else if (r < 88) begin
      b = ($urandom_range(0, 1) ? SPAN_S : 64'd0) - offset_secs(cur_offset, cur_dst)
          + longint'($urandom_range(0, 400)) - 200;
    end else begin
      return $urandom;
    end
    return ntp_of(b);
  endfunction

  // ------------------------------------------------------------------ driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        calendar_due.push_back(ntp_to_calendar(s_axis_tdata, cur_offset, cur_dst));
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ntp_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tdata  <= ntp_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_UTC_OFFSET) cur_offset <= cfg_data_i[10:0];
        else if (cfg_index_i == REG_DST) cur_dst <= cfg_data_i[0];
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_backlog.size() > 0) begin
          reg_write_t w;
          w = reg_backlog.pop_front();
          cfg_index_i <= w.idx;
          cfg_data_i  <= w.data;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // free-running cycle count; the receiver holds off until hold_until
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ----------------------------------------------------------------- monitor
  task automatic flag_mismatch(string what, logic [31:0] ntp, longint got, longint want);
    mismatch_count++;
    $display("mismatch %s for ntp %08h: got %0h, want %0h", what, ntp, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        dates_seen++;
        if (m_axis_tuser) oor_seen++;
        if (calendar_due.size() == 0) begin
          flag_mismatch("unexpected transfer", '0, {m_axis_tuser, m_axis_tdata}, 0);
        end else begin
          calendar_t   want;
          logic [40:0] got_bits;
          int          lsb[8] = '{0, 8, 13, 19, 25, 32, 39, 40};
          int          wid[8] = '{8, 5, 6, 6, 7, 7, 1, 1};
          string       nm[8] = '{"year", "month", "day", "hour", "minute", "second",
                                 "pad", "out_of_range"};
          want = calendar_due.pop_front();
          got_bits = {m_axis_tuser, m_axis_tdata};
          for (int k = 0; k < 8; k++) begin
            longint g, e;
            g = longint'((got_bits >> lsb[k]) & ((41'd1 << wid[k]) - 1));
            e = longint'(({want.oor, want.date} >> lsb[k]) & ((41'd1 << wid[k]) - 1));
            if (g != e) flag_mismatch(nm[k], want.ntp, g, e);
          end
        end
      end
      m_axis_tready <= (cycle_cnt >= hold_until) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic wait_drained();
    do @(negedge clk_i);
    while (ntp_backlog.size() != 0 || s_axis_tvalid || calendar_due.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [10:0] off, logic dst, bit stray);
    reg_backlog.push_back('{idx: REG_UTC_OFFSET,
                            data: {5'($urandom), off}});
    reg_backlog.push_back('{idx: REG_DST, data: {15'($urandom), dst}});
    // writes to unmapped indexes must leave both registers alone
    if (stray) reg_backlog.push_back('{idx: CFG_IW'($urandom_range(2, 255)),
                                       data: CFG_DW'($urandom)});
    do @(negedge clk_i);
    while (reg_backlog.size() != 0 || cfg_valid_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [10:0] off, logic dst, int idle, int stall, int hold);
    write_regs(off, dst, 1'($urandom_range(0, 1)));
    idle_pct = idle;
    stall_pct = stall;
    hold_until = cycle_cnt + hold;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) ntp_backlog.push_back(random_ntp());
    wait_drained();
  endtask

  initial begin
    longint edge_bases[17] = '{0, 1, 59, 60, 3599, 3600, 86399, 86400,
                               31 * DAY_S - 1, 59 * DAY_S, 60 * DAY_S,
                               366 * DAY_S - 1, 366 * DAY_S, 1520 * DAY_S,
                               1520 * DAY_S + 86399, SPAN_S - 1, SPAN_S};
    @(posedge rst_ni);
    @(negedge clk_i);
    // reset setting: offset 0, no DST
    foreach (edge_bases[i]) ntp_backlog.push_back(ntp_of(edge_bases[i]));
    ntp_backlog.push_back(32'h0000_0000);
    ntp_backlog.push_back(32'hFFFF_FFFF);
    ntp_backlog.push_back(32'(EPOCH_NTP_S - 1));
    ntp_backlog.push_back(32'hAAAA_AAAA);
    ntp_backlog.push_back(32'h5555_5555);
    wait_drained();

    run_phase(11'd0, 1'b0, 0, 0, 0);
    run_phase(11'(-720), 1'b0, 49, 0, 0);
    run_phase(11'd840, 1'b1, 0, 49, 0);
    run_phase(11'h400, 1'b1, 34, 34, 0);
    // long output hold-off while the sender keeps offering
    run_phase(11'h3FF, 1'b0, 0, 0, HOLD_CYCLES);
    run_phase(11'($urandom), 1'($urandom), 34, 34, 0);

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("checked %0d conversions (%0d out of range) across seven offset/DST settings",
             dates_seen, oor_seen);
    $display("%0d items taken, %0d mismatches", items_taken, mismatch_count);
    if (mismatch_count == 0 && calendar_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
